// ===== design/ptt_pkg.sv =====
`default_nettype none

package ptt_pkg;

    localparam int PAGE_COUNT = 16;
    localparam int FRAME_BITS = 16;
    localparam int IDX_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    localparam int PAGE_W     = 16;
    localparam int IN_FRAME_W = 16;
    localparam int ADDR_W     = 32;
    localparam int CFG_W      = 5;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [CFG_W-1:0] PAGE_SHIFT_RST   = 5'd9;
    localparam logic [CFG_W-1:0] PAGES_IN_USE_RST = 5'd16;

    // Register word index taken from paddr
    localparam logic REG_PAGE_SHIFT   = 1'b0;
    localparam logic REG_PAGES_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        CMD_MAP       = 2'd0,
        CMD_UNMAP     = 2'd1,
        CMD_TRANSLATE = 2'd2,
        CMD_WRITE     = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FAULT = 2'd2
    } status_t;

    typedef struct packed {
        command_t                  cmd;
        logic [PAGE_W-1:0]         page;
        logic [IN_FRAME_W-1:0]     frame;
        logic [ADDR_W-1:0]         vaddr;
    } request_t;

    typedef struct packed {
        status_t                   status;
        logic [ADDR_W-1:0]         paddr;
        logic                      dirty;
        logic                      referenced;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0]          page_shift;
        logic [CFG_W-1:0]          pages_in_use;
    } config_t;

endpackage

`default_nettype wire

// ===== design/ptt_cfg.sv =====
`default_nettype none

module ptt_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ptt_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [ptt_pkg::PDATA_W-1:0]     pwdata,
    output logic      [ptt_pkg::PDATA_W-1:0]     prdata,
    output logic                                 pready,
    output ptt_pkg::config_t                     cfg
);

    logic [ptt_pkg::CFG_W-1:0] page_shift_reg;
    logic [ptt_pkg::CFG_W-1:0] page_shift_next;
    logic [ptt_pkg::CFG_W-1:0] pages_in_use_reg;
    logic [ptt_pkg::CFG_W-1:0] pages_in_use_next;
    logic                      wr_en;
    logic                      reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign reg_index = paddr[2];

    always_comb
    begin
        page_shift_next   = page_shift_reg;
        pages_in_use_next = pages_in_use_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                ptt_pkg::REG_PAGE_SHIFT:
                    page_shift_next = pwdata[ptt_pkg::CFG_W-1:0];
                ptt_pkg::REG_PAGES_IN_USE:
                    pages_in_use_next = pwdata[ptt_pkg::CFG_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg   <= ptt_pkg::PAGE_SHIFT_RST;
            pages_in_use_reg <= ptt_pkg::PAGES_IN_USE_RST;
        end
        else
        begin
            page_shift_reg   <= page_shift_next;
            pages_in_use_reg <= pages_in_use_next;
        end
    end

    always_comb
    begin
        unique case (reg_index)
            ptt_pkg::REG_PAGE_SHIFT:
                prdata = ptt_pkg::PDATA_W'(page_shift_reg);
            ptt_pkg::REG_PAGES_IN_USE:
                prdata = ptt_pkg::PDATA_W'(pages_in_use_reg);
        endcase
    end

    assign cfg.page_shift   = page_shift_reg;
    assign cfg.pages_in_use = pages_in_use_reg;

endmodule

`default_nettype wire

// ===== design/ptt_table.sv =====
`default_nettype none

module ptt_table (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  ptt_pkg::request_t      req,
    input  ptt_pkg::config_t       cfg,
    output ptt_pkg::result_t       res
);

    logic [ptt_pkg::PAGE_COUNT-1:0] valid_reg;
    logic [ptt_pkg::PAGE_COUNT-1:0] valid_next;
    logic [ptt_pkg::PAGE_COUNT-1:0] dirty_reg;
    logic [ptt_pkg::PAGE_COUNT-1:0] dirty_next;
    logic [ptt_pkg::PAGE_COUNT-1:0] ref_reg;
    logic [ptt_pkg::PAGE_COUNT-1:0] ref_next;
    logic [ptt_pkg::FRAME_BITS-1:0] frame_store_reg [ptt_pkg::PAGE_COUNT];

    logic [ptt_pkg::ADDR_W-1:0]     page_num;
    logic [ptt_pkg::ADDR_W-1:0]     limit;
    logic [ptt_pkg::ADDR_W-1:0]     offset_mask;
    logic [ptt_pkg::ADDR_W-1:0]     frame_ext;
    logic [ptt_pkg::IDX_W-1:0]      idx;
    logic                           in_range;
    logic                           hit;
    logic                           map_en;

    // Page number comes from the request for map/unmap, else from the address
    always_comb
    begin
        if (req.cmd == ptt_pkg::CMD_MAP || req.cmd == ptt_pkg::CMD_UNMAP)
            page_num = ptt_pkg::ADDR_W'(req.page);
        else
            page_num = req.vaddr >> cfg.page_shift;
    end

    // Saturate the range limit at the table depth
    always_comb
    begin
        if (ptt_pkg::ADDR_W'(cfg.pages_in_use) > ptt_pkg::ADDR_W'(ptt_pkg::PAGE_COUNT))
            limit = ptt_pkg::ADDR_W'(ptt_pkg::PAGE_COUNT);
        else
            limit = ptt_pkg::ADDR_W'(cfg.pages_in_use);
    end

    assign in_range    = page_num < limit;
    assign idx         = page_num[ptt_pkg::IDX_W-1:0];
    assign hit         = valid_reg[idx];
    assign offset_mask = (ptt_pkg::ADDR_W'(1) << cfg.page_shift) - ptt_pkg::ADDR_W'(1);
    assign frame_ext   = ptt_pkg::ADDR_W'(frame_store_reg[idx]);
    assign map_en      = step && in_range && (req.cmd == ptt_pkg::CMD_MAP);

    always_comb
    begin
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        ref_next       = ref_reg;
        res.status     = ptt_pkg::ST_DONE;
        res.paddr      = '0;
        res.dirty      = 1'b0;
        res.referenced = 1'b0;
        if (!in_range)
        begin
            res.status = ptt_pkg::ST_RANGE;
        end
        else
        begin
            unique case (req.cmd)
                ptt_pkg::CMD_MAP:
                    valid_next[idx] = 1'b1;
                ptt_pkg::CMD_UNMAP:
                    valid_next[idx] = 1'b0;
                ptt_pkg::CMD_TRANSLATE:
                begin
                    if (!hit)
                        res.status = ptt_pkg::ST_FAULT;
                    else
                    begin
                        ref_next[idx] = 1'b1;
                        res.paddr     = (frame_ext << cfg.page_shift)
                                        | (req.vaddr & offset_mask);
                    end
                end
                ptt_pkg::CMD_WRITE:
                begin
                    if (!hit)
                        res.status = ptt_pkg::ST_FAULT;
                    else
                    begin
                        dirty_next[idx] = 1'b1;
                        ref_next[idx]   = 1'b1;
                    end
                end
            endcase
            res.dirty      = dirty_next[idx];
            res.referenced = ref_next[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            ref_reg   <= '0;
        end
        else if (step)
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            ref_reg   <= ref_next;
        end
    end

    // Frames are only read behind a set valid bit, so no reset
    always_ff @(posedge clk)
    begin
        if (map_en)
            frame_store_reg[idx] <= ptt_pkg::FRAME_BITS'(req.frame);
    end

endmodule

`default_nettype wire

// ===== design/page_table_translator.sv =====
`default_nettype none

// Single-level page table of 16 entries (frame number plus valid, dirty and
// referenced flags). Accepts one request every clock cycle while the output is
// not stalled. The request is registered, then the flag and frame registers are
// read, updated and the result registered in the same cycle, so back-to-back
// requests to the same page see each other's updates. A stalled result holds
// the request register; a new request is still taken while that register is
// empty or moving on. The page size and the number of pages in range are set
// through the APB port (page_shift at 0x0, reset 9; pages_in_use at 0x4,
// reset 16) and must only be changed while idle.
module page_table_translator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ptt_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [ptt_pkg::PDATA_W-1:0]         pwdata,
    output logic      [ptt_pkg::PDATA_W-1:0]         prdata,
    output logic                                     pready,

    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [1:0]                          command,
    input  wire logic [ptt_pkg::PAGE_W-1:0]          page,
    input  wire logic [ptt_pkg::IN_FRAME_W-1:0]      frame,
    input  wire logic [ptt_pkg::ADDR_W-1:0]          virtual_address,

    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [1:0]                               status,
    output logic [ptt_pkg::ADDR_W-1:0]               physical_address,
    output logic                                     entry_dirty,
    output logic                                     entry_referenced
);

    ptt_pkg::config_t  cfg;
    ptt_pkg::request_t req_reg;
    ptt_pkg::result_t  res;
    ptt_pkg::result_t  res_reg;

    logic req_valid_reg;
    logic req_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic advance;
    logic step;
    logic take;

    ptt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ptt_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .req   (req_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign advance  = !out_valid_reg || out_ready;
    assign step     = req_valid_reg && advance;
    assign in_ready = !req_valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        if (take)
            req_valid_next = 1'b1;
        else if (step)
            req_valid_next = 1'b0;
        else
            req_valid_next = req_valid_reg;

        if (step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request and hold the result until taken
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg.cmd   <= ptt_pkg::command_t'(command);
            req_reg.page  <= page;
            req_reg.frame <= frame;
            req_reg.vaddr <= virtual_address;
        end
        if (step)
            res_reg <= res;
    end

    assign out_valid        = out_valid_reg;
    assign status           = res_reg.status;
    assign physical_address = res_reg.paddr;
    assign entry_dirty      = res_reg.dirty;
    assign entry_referenced = res_reg.referenced;

endmodule

`default_nettype wire

// ===== design/ptt_checker.sv =====
`default_nettype none

module ptt_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                pready,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic [1:0]                          status,
    input  wire logic [ptt_pkg::ADDR_W-1:0]          physical_address,
    input  wire logic                                entry_dirty,
    input  wire logic                                entry_referenced
);

    // The register port never stalls
    assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("register port stalled");

    // A stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(physical_address))
    else $error("result changed while stalled");

    // Only a successful translate gives an address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ptt_pkg::ST_DONE |-> physical_address == '0)
    else $error("address given on an error status");

    // Out-of-range pages report clear flags
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ptt_pkg::ST_RANGE |-> !entry_dirty && !entry_referenced)
    else $error("flags set on an out-of-range page");

    // Dirty is always set together with referenced
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_dirty |-> entry_referenced)
    else $error("dirty page not marked referenced");

endmodule

bind page_table_translator ptt_checker u_ptt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pready           (pready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .physical_address (physical_address),
    .entry_dirty      (entry_dirty),
    .entry_referenced (entry_referenced)
);

`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
    import ptt_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int CHUNK_ITEMS  = 100;

    localparam logic [PADDR_W-1:0] ADDR_PAGE_SHIFT   = {REG_PAGE_SHIFT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_PAGES_IN_USE = {REG_PAGES_IN_USE, 2'b00};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            command = 2'b00;
    logic [PAGE_W-1:0]     page = '0;
    logic [IN_FRAME_W-1:0] frame = '0;
    logic [ADDR_W-1:0]     virtual_address = '0;

    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            status;
    logic [ADDR_W-1:0]     physical_address;
    logic                  entry_dirty;
    logic                  entry_referenced;

    // Shadow copy of the page table and its settings
    logic [FRAME_BITS-1:0] frame_tbl [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] valid_map = '0;
    logic [PAGE_COUNT-1:0] dirty_map = '0;
    logic [PAGE_COUNT-1:0] referenced_map = '0;
    logic [CFG_W-1:0]      cfg_shift = PAGE_SHIFT_RST;
    logic [CFG_W-1:0]      cfg_pages = PAGES_IN_USE_RST;

    result_t pending_results [$];

    int src_idle_pct = 28;
    int snk_idle_pct = 51;
    int mismatches = 0;
    int cycle_count = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int settings_applied = 0;
    int count_done = 0;
    int count_range = 0;
    int count_fault = 0;

    page_table_translator u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .page             (page),
        .frame            (frame),
        .virtual_address  (virtual_address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .physical_address (physical_address),
        .entry_dirty      (entry_dirty),
        .entry_referenced (entry_referenced)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("run stopped by timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    function automatic result_t translate_request(input logic [1:0] cmd,
                                                  input logic [15:0] pg_in,
                                                  input logic [15:0] fr,
                                                  input logic [31:0] va);
        result_t     res;
        logic [63:0] pg;
        logic [63:0] lim;
        logic [63:0] va64;
        logic [63:0] base;
        logic [63:0] wide;
        int          idx;
        res = '0;
        va64 = va;
        lim = (cfg_pages > PAGE_COUNT) ? PAGE_COUNT : cfg_pages;
        if (cmd == CMD_MAP || cmd == CMD_UNMAP)
            pg = pg_in;
        else
            pg = va64 >> cfg_shift;
        if (pg >= lim)
        begin
            res.status = ST_RANGE;
        end
        else
        begin
            idx = pg[IDX_W-1:0];
            case (cmd)
                CMD_MAP:
                begin
                    frame_tbl[idx] = fr;
                    valid_map[idx] = 1'b1;
                end
                CMD_UNMAP:
                begin
                    valid_map[idx] = 1'b0;
                end
                CMD_TRANSLATE:
                begin
                    if (!valid_map[idx])
                        res.status = ST_FAULT;
                    else
                    begin
                        referenced_map[idx] = 1'b1;
                        base = frame_tbl[idx];
                        wide = (base << cfg_shift) | (va64 & ((64'd1 << cfg_shift) - 64'd1));
                        res.paddr = wide[31:0];
                    end
                end
                default:
                begin
                    if (!valid_map[idx])
                        res.status = ST_FAULT;
                    else
                    begin
                        dirty_map[idx] = 1'b1;
                        referenced_map[idx] = 1'b1;
                    end
                end
            endcase
            res.dirty = dirty_map[idx];
            res.referenced = referenced_map[idx];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 50)
            $display("mismatch %0d at cycle %0d: %s got 0x%0h want 0x%0h",
                     mismatches, cycle_count, what, got, want);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending, status", status, 0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (physical_address !== want.paddr)
                    report_mismatch("physical_address", physical_address, want.paddr);
                if (entry_dirty !== want.dirty)
                    report_mismatch("entry_dirty", entry_dirty, want.dirty);
                if (entry_referenced !== want.referenced)
                    report_mismatch("entry_referenced", entry_referenced, want.referenced);
                case (want.status)
                    ST_DONE:  count_done++;
                    ST_RANGE: count_range++;
                    default:  count_fault++;
                endcase
            end
        end
        if (rst_n && in_valid && in_ready)
            pending_results.push_back(translate_request(command, page, frame,
                                                        virtual_address));
    end

    task automatic send_request(input command_t cmd, input logic [15:0] pg,
                                input logic [15:0] fr, input logic [31:0] va);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        page <= pg;
        frame <= fr;
        virtual_address <= va;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_register(input logic [PADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        logic [PDATA_W-1:0] noise;
        noise = $urandom;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {noise[PDATA_W-1:CFG_W], value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_PAGE_SHIFT)
            cfg_shift = value;
        else
            cfg_pages = value;
        // read back through a second transfer
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[CFG_W-1:0] !== value)
            report_mismatch("register read-back", prdata, value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] shift_val,
                                 input logic [CFG_W-1:0] pages_val);
        drain_results();
        set_register(ADDR_PAGE_SHIFT, shift_val);
        set_register(ADDR_PAGES_IN_USE, pages_val);
    endtask

    // Reset settings: 512-byte pages, all sixteen pages in range
    task automatic test_directed_defaults();
        send_request(CMD_TRANSLATE, 16'h0000, 16'h0000, 32'h0000_0000);
        send_request(CMD_WRITE,     16'hFFFF, 16'hFFFF, 32'h0000_0010);
        send_request(CMD_UNMAP,     16'd3,    16'h0000, 32'h0000_0000);
        send_request(CMD_MAP,       16'd0,    16'hFFFF, 32'h0000_0000);
        send_request(CMD_MAP,       16'd15,   16'h0000, 32'hFFFF_FFFF);
        send_request(CMD_MAP,       16'd16,   16'h0001, 32'h0000_0000);
        send_request(CMD_MAP,       16'hFFFF, 16'hFFFF, 32'h0000_0000);
        send_request(CMD_TRANSLATE, 16'h0000, 16'h0000, 32'h0000_01FF);
        send_request(CMD_WRITE,     16'h0000, 16'h0000, 32'h0000_1E00);
        send_request(CMD_TRANSLATE, 16'h0000, 16'h0000, 32'h0000_1F55);
        // remap keeps the dirty and referenced flags
        send_request(CMD_MAP,       16'd15,   16'hAAAA, 32'h0000_0000);
        send_request(CMD_TRANSLATE, 16'h0000, 16'h0000, 32'h0000_1E01);
        send_request(CMD_UNMAP,     16'd15,   16'h0000, 32'h0000_0000);
        send_request(CMD_TRANSLATE, 16'h0000, 16'h0000, 32'h0000_1E00);
        send_request(CMD_WRITE,     16'h0000, 16'h0000, 32'h0000_1E00);
        send_request(CMD_UNMAP,     16'd15,   16'h0000, 32'h0000_0000);
        send_request(CMD_MAP,       16'd15,   16'h5555, 32'h0000_0000);
        send_request(CMD_TRANSLATE, 16'h0000, 16'h0000, 32'h0000_1FFF);
        send_request(CMD_TRANSLATE, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_request(CMD_WRITE,     16'h0000, 16'h0000, 32'h0000_2000);
    endtask

    task automatic test_config_extremes();
        // no page in range at all
        apply_setting(5'd0, 5'd0);
        send_request(CMD_MAP,       16'd0,    16'h1234, 32'h0000_0000);
        send_request(CMD_TRANSLATE, 16'h0000, 16'h0000, 32'h0000_0000);
        // byte-sized pages, one page in range
        apply_setting(5'd0, 5'd1);
        send_request(CMD_MAP,       16'd0,    16'hFFFF, 32'h0000_0000);
        send_request(CMD_TRANSLATE, 16'h0000, 16'h0000, 32'h0000_0000);
        send_request(CMD_TRANSLATE, 16'h0000, 16'h0000, 32'h0000_0001);
        // widest shift; page count above the table size saturates
        apply_setting(5'd31, 5'd31);
        send_request(CMD_MAP,       16'd1,    16'h0001, 32'h0000_0000);
        send_request(CMD_TRANSLATE, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        send_request(CMD_TRANSLATE, 16'h0000, 16'h0000, 32'h1234_5678);
        apply_setting(5'd16, 5'd16);
        send_request(CMD_TRANSLATE, 16'h0000, 16'h0000, 32'h000F_ABCD);
        send_request(CMD_TRANSLATE, 16'h0000, 16'h0000, 32'hFFFF_0000);
    endtask

    task automatic test_random_traffic(input int chunks, input int src_pct, input int snk_pct);
        command_t    cmd;
        logic [15:0] pg;
        logic [15:0] pg_field;
        logic [31:0] va;
        logic [63:0] wide;
        logic [63:0] rnd;
        logic [4:0]  shift_val;
        logic [4:0]  pages_val;
        int          lim;
        int          pick;
        bit          noisy;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int c = 0; c < chunks; c++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                pages_val = 5'd0;
            else if (pick < 18)
                pages_val = 5'($urandom_range(17, 31));
            else
                pages_val = 5'($urandom_range(1, 16));
            shift_val = 5'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 12)
                                                        : $urandom_range(13, 31));
            apply_setting(shift_val, pages_val);
            lim = (cfg_pages > PAGE_COUNT) ? PAGE_COUNT : cfg_pages;
            for (int n = 0; n < CHUNK_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    cmd = CMD_MAP;
                else if (pick < 42)
                    cmd = CMD_UNMAP;
                else if (pick < 78)
                    cmd = CMD_TRANSLATE;
                else
                    cmd = CMD_WRITE;
                // mostly in-range pages, now and then anything at all
                noisy = ($urandom_range(0, 9) == 0);
                if (noisy || lim == 0)
                    pg = 16'($urandom);
                else
                    pg = 16'($urandom_range(0, lim - 1));
                rnd = 64'($urandom);
                wide = (rnd & ((64'd1 << cfg_shift) - 64'd1)) | ({48'b0, pg} << cfg_shift);
                va = noisy ? $urandom : wide[31:0];
                pg_field = (cmd == CMD_MAP || cmd == CMD_UNMAP) ? pg : 16'($urandom);
                send_request(cmd, pg_field, 16'($urandom), va);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_defaults();
        test_config_extremes();
        test_random_traffic(7, 28, 51);
        test_random_traffic(7, 51, 28);
        test_random_traffic(6, 0, 0);
        drain_results();
        repeat (8) @(posedge clk);
        $display("Checked %0d results for %0d requests across %0d register writes",
                 results_seen, requests_sent, settings_applied);
        $display("Outcomes: %0d done, %0d out of range, %0d page faults",
                 count_done, count_range, count_fault);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
